/* rtl/bmp_stream_decoder_macros.svh */
// Assertion macros for the BMP stream decoder.
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsd assertion failed");
// Next-cycle implication, checked out of reset.
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsd assertion failed");
`else
`define BSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/bsd_pkg.sv */
// Shared types and constants of the BMP stream decoder.
`default_nettype none
package bsd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MAX_STEP    = 8;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int ERR_W       = 3;
  localparam int COORD_W     = 11;
  localparam int DIM_W       = 12;
  localparam int RGB_W       = 24;
  localparam int STEP_W      = 4;
  localparam int CNT_W       = 4;   // holds 0..MAX_STEP
  localparam int MOD_W       = 3;   // holds 0..MAX_STEP-1
  localparam int ROWB_W      = 14;  // padded row bytes, up to 4*MAX_WIDTH
  localparam int HDR_IDX_W   = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [15:0] DEPTH_32      = 16'd32;

  // Header byte positions
  localparam logic [HDR_IDX_W-1:0] IDX_SIG_LAST = 6'd1;
  localparam logic [HDR_IDX_W-1:0] IDX_SIG_CHK  = 6'd13;
  localparam logic [HDR_IDX_W-1:0] IDX_WIDTH    = 6'd18;
  localparam logic [HDR_IDX_W-1:0] IDX_HEIGHT   = 6'd22;
  localparam logic [HDR_IDX_W-1:0] IDX_DEPTH    = 6'd28;
  localparam logic [HDR_IDX_W-1:0] IDX_HDR_LAST = 6'd53;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_SIZE      = 3'd2,
    ERR_DEPTH     = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  // Work for the emitter caused by one byte: a run of pixel writes, then
  // an optional completion or error result.
  typedef struct packed {
    logic [CNT_W-1:0]   pix_cnt;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RGB_W-1:0]   rgb;
    logic               tail_vld;
    kind_t              tail_kind;
    err_t               tail_err;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

/* rtl/bsd_if.sv */
// Stream channel interfaces of the BMP stream decoder.
`default_nettype none
interface bsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsd_pkg::BYTE_W-1:0] file_byte;
  logic                        end_of_file;

  modport source (output valid, file_byte, end_of_file, input ready);
  modport sink   (input valid, file_byte, end_of_file, output ready);
endinterface

interface bsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsd_pkg::KIND_W-1:0]  result_kind;
  logic [bsd_pkg::ERR_W-1:0]   error_code;
  logic [bsd_pkg::COORD_W-1:0] pixel_x;
  logic [bsd_pkg::COORD_W-1:0] pixel_y;
  logic [bsd_pkg::RGB_W-1:0]   pixel_rgb;
  logic [bsd_pkg::DIM_W-1:0]   image_width;
  logic [bsd_pkg::DIM_W-1:0]   image_height;
  logic                         last_of_run;

  modport source (output valid, result_kind, error_code, pixel_x, pixel_y, pixel_rgb,
                  image_width, image_height, last_of_run, input ready);
  modport sink   (input valid, result_kind, error_code, pixel_x, pixel_y, pixel_rgb,
                  image_width, image_height, last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/bsd_front.sv */
// Byte parser: header capture and checks, pixel assembly, job generation.
`default_nettype none
module bsd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [bsd_pkg::STEP_W-1:0] step,
  input  wire logic                        byte_vld,
  input  wire logic [bsd_pkg::BYTE_W-1:0] byte_data,
  input  wire logic                        byte_eof,
  output bsd_pkg::job_t                    job,
  output logic                             job_push
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [bsd_pkg::HDR_IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]                      sig_r, sig_nxt;
  logic [31:0]                      width_r, width_nxt;
  logic [31:0]                      height_r, height_nxt;
  logic [15:0]                      depth_r, depth_nxt;
  logic [bsd_pkg::COORD_W-1:0]     row_r, row_nxt;
  logic [bsd_pkg::ROWB_W-1:0]      bir_r, bir_nxt;
  logic [15:0]                      asm_r, asm_nxt;
  logic [1:0]                       bip_r, bip_nxt;
  logic [bsd_pkg::COORD_W-1:0]     col_r, col_nxt;
  logic [bsd_pkg::MOD_W-1:0]       mod_r   [2:bsd_pkg::MAX_STEP];
  logic [bsd_pkg::MOD_W-1:0]       mod_nxt [2:bsd_pkg::MAX_STEP];

  // Image geometry latched at the end of the header
  logic [bsd_pkg::DIM_W-1:0]       w_r, w_nxt;
  logic [bsd_pkg::DIM_W-1:0]       h_r, h_nxt;
  logic                             bpp4_r, bpp4_nxt;
  logic                             bup_r, bup_nxt;
  logic [bsd_pkg::ROWB_W-1:0]      data_r, data_nxt;
  logic [bsd_pkg::ROWB_W-1:0]      rowb_r, rowb_nxt;

  logic                             h_neg;
  logic [31:0]                      h_abs;
  logic                             bad_size;
  logic                             bad_depth;
  logic [bsd_pkg::ROWB_W-1:0]      hdr_data;
  logic [bsd_pkg::ROWB_W-1:0]      pad_sum;
  logic [bsd_pkg::HDR_IDX_W-1:0]   off_w, off_h, off_d;

  logic [bsd_pkg::CNT_W-1:0]       stepc;
  logic                             step_hit;
  logic [bsd_pkg::DIM_W-1:0]       rem;
  logic [bsd_pkg::CNT_W-1:0]       cnt;
  logic [bsd_pkg::DIM_W-1:0]       y_flip;
  logic [bsd_pkg::COORD_W-1:0]     y_pix;
  logic                             in_data;
  logic                             pix_end;
  logic [bsd_pkg::ROWB_W-1:0]      bir_inc;
  logic                             row_last;

  // Header checks on captured words
  always_comb begin
    h_neg     = height_r[31];
    h_abs     = h_neg ? (32'd0 - height_r) : height_r;
    bad_size  = width_r[31] || (width_r == 32'd0) || (width_r > 32'(bsd_pkg::MAX_WIDTH)) ||
                (h_abs == 32'd0) || (h_abs > 32'(bsd_pkg::MAX_HEIGHT));
    bad_depth = (depth_r != bsd_pkg::DEPTH_24) && (depth_r != bsd_pkg::DEPTH_32);
    if (depth_r == bsd_pkg::DEPTH_32) begin
      hdr_data = bsd_pkg::ROWB_W'({width_r[bsd_pkg::DIM_W-1:0], 2'b00});
    end else begin
      hdr_data = bsd_pkg::ROWB_W'({width_r[bsd_pkg::DIM_W-1:0], 1'b0}) +
                 bsd_pkg::ROWB_W'(width_r[bsd_pkg::DIM_W-1:0]);
    end
    pad_sum = hdr_data + bsd_pkg::ROWB_W'(3);
    off_w   = idx_r - bsd_pkg::IDX_WIDTH;
    off_h   = idx_r - bsd_pkg::IDX_HEIGHT;
    off_d   = idx_r - bsd_pkg::IDX_DEPTH;
  end

  // Sampling: one mod-k counter per step value 2..MAX_STEP tracks column mod k
  always_comb begin
    if (step == '0) begin
      stepc = bsd_pkg::CNT_W'(1);
    end else if (step > bsd_pkg::STEP_W'(bsd_pkg::MAX_STEP)) begin
      stepc = bsd_pkg::CNT_W'(bsd_pkg::MAX_STEP);
    end else begin
      stepc = bsd_pkg::CNT_W'(step);
    end
    step_hit = (stepc == bsd_pkg::CNT_W'(1));
    for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
      if ((stepc == bsd_pkg::CNT_W'(k)) && (mod_r[k] == '0)) begin
        step_hit = 1'b1;
      end
    end
    rem = w_r - bsd_pkg::DIM_W'(col_r);
    if (!step_hit) begin
      cnt = '0;
    end else if (rem < bsd_pkg::DIM_W'(stepc)) begin
      cnt = bsd_pkg::CNT_W'(rem);
    end else begin
      cnt = stepc;
    end
    y_flip   = h_r - bsd_pkg::DIM_W'(1) - bsd_pkg::DIM_W'(row_r);
    y_pix    = bup_r ? y_flip[bsd_pkg::COORD_W-1:0] : row_r;
    in_data  = bir_r < data_r;
    pix_end  = bpp4_r ? (bip_r == 2'd3) : (bip_r == 2'd2);
    bir_inc  = bir_r + bsd_pkg::ROWB_W'(1);
    row_last = (bsd_pkg::DIM_W'(row_r) + bsd_pkg::DIM_W'(1)) >= h_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    sig_nxt    = sig_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    row_nxt    = row_r;
    bir_nxt    = bir_r;
    asm_nxt    = asm_r;
    bip_nxt    = bip_r;
    col_nxt    = col_r;
    mod_nxt    = mod_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    bpp4_nxt   = bpp4_r;
    bup_nxt    = bup_r;
    data_nxt   = data_r;
    rowb_nxt   = rowb_r;
    job        = '0;

    if (byte_vld) begin
      case (phase_r)
        PH_HEADER: begin
          if (idx_r <= bsd_pkg::IDX_SIG_LAST) begin
            sig_nxt[8*idx_r[0] +: 8] = byte_data;
          end else if (idx_r >= bsd_pkg::IDX_WIDTH && idx_r < bsd_pkg::IDX_HEIGHT) begin
            width_nxt[8*off_w[1:0] +: 8] = byte_data;
          end else if (idx_r >= bsd_pkg::IDX_HEIGHT && idx_r < bsd_pkg::IDX_HEIGHT + 6'd4) begin
            height_nxt[8*off_h[1:0] +: 8] = byte_data;
          end else if (idx_r >= bsd_pkg::IDX_DEPTH && idx_r < bsd_pkg::IDX_DEPTH + 6'd2) begin
            depth_nxt[8*off_d[0] +: 8] = byte_data;
          end

          if (idx_r == bsd_pkg::IDX_SIG_CHK && sig_r != bsd_pkg::BMP_SIGNATURE) begin
            job.tail_vld  = 1'b1;
            job.tail_kind = bsd_pkg::KIND_ERROR;
            job.tail_err  = bsd_pkg::ERR_SIGNATURE;
            phase_nxt     = PH_ERROR;
          end else if (idx_r >= bsd_pkg::IDX_HDR_LAST) begin
            if (bad_size) begin
              job.tail_vld  = 1'b1;
              job.tail_kind = bsd_pkg::KIND_ERROR;
              job.tail_err  = bsd_pkg::ERR_SIZE;
              phase_nxt     = PH_ERROR;
            end else if (bad_depth) begin
              job.tail_vld  = 1'b1;
              job.tail_kind = bsd_pkg::KIND_ERROR;
              job.tail_err  = bsd_pkg::ERR_DEPTH;
              phase_nxt     = PH_ERROR;
            end else begin
              phase_nxt = PH_PIXELS;
              row_nxt   = '0;
              bir_nxt   = '0;
              bip_nxt   = '0;
              asm_nxt   = '0;
              col_nxt   = '0;
              for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
                mod_nxt[k] = '0;
              end
              w_nxt    = width_r[bsd_pkg::DIM_W-1:0];
              h_nxt    = h_abs[bsd_pkg::DIM_W-1:0];
              bpp4_nxt = (depth_r == bsd_pkg::DEPTH_32);
              bup_nxt  = !h_neg;
              data_nxt = hdr_data;
              rowb_nxt = {pad_sum[bsd_pkg::ROWB_W-1:2], 2'b00};
            end
          end else begin
            idx_nxt = idx_r + bsd_pkg::HDR_IDX_W'(1);
          end
        end

        PH_PIXELS: begin
          if (in_data) begin
            if (bip_r == 2'd0) begin
              asm_nxt[7:0] = byte_data;
            end else if (bip_r == 2'd1) begin
              asm_nxt[15:8] = byte_data;
            end
            // Red byte: all writes of the pixel go out now
            if (bip_r == 2'd2) begin
              job.pix_cnt = cnt;
              job.x       = col_r;
              job.y       = y_pix;
              job.rgb     = {byte_data, asm_r[15:8], asm_r[7:0]};
            end
            if (pix_end) begin
              bip_nxt = '0;
              col_nxt = col_r + bsd_pkg::COORD_W'(1);
              for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
                mod_nxt[k] = (mod_r[k] == bsd_pkg::MOD_W'(k - 1)) ? '0 :
                             mod_r[k] + bsd_pkg::MOD_W'(1);
              end
            end else begin
              bip_nxt = bip_r + 2'd1;
            end
          end
          if (bir_inc >= rowb_r) begin
            bir_nxt = '0;
            bip_nxt = '0;
            col_nxt = '0;
            for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
              mod_nxt[k] = '0;
            end
            if (row_last) begin
              job.tail_vld  = 1'b1;
              job.tail_kind = bsd_pkg::KIND_DONE;
              job.tail_err  = bsd_pkg::ERR_NONE;
              job.img_w     = w_r;
              job.img_h     = h_r;
              phase_nxt     = PH_DONE;
            end else begin
              row_nxt = row_r + bsd_pkg::COORD_W'(1);
            end
          end else begin
            bir_nxt = bir_inc;
          end
        end

        default: begin
        end
      endcase

      if (byte_eof) begin
        if (phase_nxt == PH_HEADER || phase_nxt == PH_PIXELS) begin
          job.tail_vld  = 1'b1;
          job.tail_kind = bsd_pkg::KIND_ERROR;
          job.tail_err  = bsd_pkg::ERR_TRUNCATED;
        end
        phase_nxt  = PH_HEADER;
        idx_nxt    = '0;
        sig_nxt    = '0;
        width_nxt  = '0;
        height_nxt = '0;
        depth_nxt  = '0;
        row_nxt    = '0;
        bir_nxt    = '0;
        asm_nxt    = '0;
        bip_nxt    = '0;
        col_nxt    = '0;
        for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
          mod_nxt[k] = '0;
        end
      end
    end
  end

  assign job_push = byte_vld && ((job.pix_cnt != '0) || job.tail_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      sig_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      row_r    <= '0;
      bir_r    <= '0;
      asm_r    <= '0;
      bip_r    <= '0;
      col_r    <= '0;
      for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
        mod_r[k] <= '0;
      end
      w_r      <= '0;
      h_r      <= '0;
      bpp4_r   <= 1'b0;
      bup_r    <= 1'b0;
      data_r   <= '0;
      rowb_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      sig_r    <= sig_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      row_r    <= row_nxt;
      bir_r    <= bir_nxt;
      asm_r    <= asm_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      for (int k = 2; k <= bsd_pkg::MAX_STEP; k++) begin
        mod_r[k] <= mod_nxt[k];
      end
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      bpp4_r   <= bpp4_nxt;
      bup_r    <= bup_nxt;
      data_r   <= data_nxt;
      rowb_r   <= rowb_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bsd_queue.sv */
// Job queue between the parser and the result emitter.
`default_nettype none
module bsd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bsd_pkg::job_t push_job,
  input  wire logic          pop,
  output bsd_pkg::job_t      head,
  output bsd_pkg::queue_stat_t stat
);

  bsd_pkg::job_t              mem_r [bsd_pkg::QUEUE_DEPTH];
  logic [bsd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bsd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bsd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    stat.full  = (cnt_r == bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + bsd_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + bsd_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + bsd_pkg::QCNT_W'(push) - bsd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bsd_back.sv */
// Result emitter: expands queued jobs into one result per cycle unless out_bus.ready stalls it.
`default_nettype none
module bsd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bsd_pkg::job_t head,
  input  wire logic          head_vld,
  output logic               pop,
  bsd_out_if.source          out_bus
);

  logic [bsd_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic                         vld_r, vld_nxt;
  logic                         load;
  logic                         is_pix;
  logic                         last;

  logic [bsd_pkg::KIND_W-1:0]  kind_r;
  logic [bsd_pkg::ERR_W-1:0]   err_r;
  logic [bsd_pkg::COORD_W-1:0] x_r;
  logic [bsd_pkg::COORD_W-1:0] y_r;
  logic [bsd_pkg::RGB_W-1:0]   rgb_r;
  logic [bsd_pkg::DIM_W-1:0]   iw_r;
  logic [bsd_pkg::DIM_W-1:0]   ih_r;
  logic                         last_r;

  always_comb begin
    load   = head_vld && (!vld_r || out_bus.ready);
    is_pix = k_r < head.pix_cnt;
    last   = is_pix ? ((bsd_pkg::CNT_W'(k_r + bsd_pkg::CNT_W'(1)) == head.pix_cnt) &&
                       !head.tail_vld) : 1'b1;
    pop    = load && last;
    k_nxt  = load ? (last ? '0 : k_r + bsd_pkg::CNT_W'(1)) : k_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_bus.ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      vld_r <= 1'b0;
    end else begin
      k_r   <= k_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= last;
      if (is_pix) begin
        kind_r <= bsd_pkg::KIND_PIXEL;
        err_r  <= bsd_pkg::ERR_NONE;
        x_r    <= head.x + bsd_pkg::COORD_W'(k_r);
        y_r    <= head.y;
        rgb_r  <= head.rgb;
        iw_r   <= '0;
        ih_r   <= '0;
      end else begin
        kind_r <= head.tail_kind;
        err_r  <= head.tail_err;
        x_r    <= '0;
        y_r    <= '0;
        rgb_r  <= '0;
        iw_r   <= head.img_w;
        ih_r   <= head.img_h;
      end
    end
  end

  assign out_bus.valid        = vld_r;
  assign out_bus.result_kind  = kind_r;
  assign out_bus.error_code   = err_r;
  assign out_bus.pixel_x      = x_r;
  assign out_bus.pixel_y      = y_r;
  assign out_bus.pixel_rgb    = rgb_r;
  assign out_bus.image_width  = iw_r;
  assign out_bus.image_height = ih_r;
  assign out_bus.last_of_run  = last_r;

endmodule
`default_nettype wire

/* rtl/bmp_stream_decoder.sv */
// Top level of the streaming BMP (24/32-bit) decoder.
//
// Usage:
//   in_bus  : one BMP file byte per transaction, end_of_file set on its last byte.
//   out_bus : results - pixel writes, image complete, or an error code;
//             last_of_run marks the final result caused by one input byte.
//   cfg_wr_en/cfg_wr_data : sample_step (1..8), written while the block is idle.
// Throughput: one byte per cycle. The emitter hands out one result per cycle
//   while out_bus.ready is high; the 4-entry job queue absorbs bursts and
//   in_bus.ready drops only when it is full.
// Path: the first result of a byte passes from the parser through the queue
//   register to the output register.
// Reset: synchronous, active low. sample_step returns to 1, the parser to the
//   file header, the queue empties and out_bus.valid drops.
// Stall: while out_bus.ready is low the output register holds its result;
//   the parser keeps taking bytes until the queue fills.
`default_nettype none
`include "bmp_stream_decoder_macros.svh"
module bmp_stream_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bsd_pkg::STEP_W-1:0] cfg_wr_data,
  bsd_in_if.sink                           in_bus,
  bsd_out_if.source                        out_bus
);

  // Live column step; the parser clips it when a pixel is issued
  logic [bsd_pkg::STEP_W-1:0] step_r;

  logic                       in_acc;
  bsd_pkg::job_t              job;
  logic                       job_push;
  bsd_pkg::job_t              head;
  logic                       pop;
  bsd_pkg::queue_stat_t       q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bsd_pkg::STEP_W'(1);
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  // Front end takes a byte whenever the queue has room
  assign in_bus.ready = !q_stat.full;
  assign in_acc       = in_bus.valid && !q_stat.full;

  bsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_r),
    .byte_vld  (in_acc),
    .byte_data (in_bus.file_byte),
    .byte_eof  (in_bus.end_of_file),
    .job       (job),
    .job_push  (job_push)
  );

  bsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  bsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_vld (!q_stat.empty),
    .pop      (pop),
    .out_bus  (out_bus)
  );

  // Completion and error results always close a byte's run
  `BSD_ASSERT_IMPLY(a_tail_is_last, clk, rst_n, out_bus.valid && out_bus.result_kind != bsd_pkg::KIND_PIXEL, out_bus.last_of_run)
  // Error code only on error results
  `BSD_ASSERT_IMPLY(a_err_only_on_error, clk, rst_n, out_bus.valid && out_bus.result_kind != bsd_pkg::KIND_ERROR, out_bus.error_code == bsd_pkg::ERR_NONE)
  // A pushed job is visible to the emitter next cycle
  `BSD_ASSERT_NEXT(a_push_not_lost, clk, rst_n, job_push, !q_stat.empty)
  // With nothing queued, a handed-off result is not repeated
  `BSD_ASSERT_NEXT(a_no_repeat, clk, rst_n, out_bus.valid && out_bus.ready && q_stat.empty, !out_bus.valid)

endmodule
`default_nettype wire

/* tb/bmp_decode_checker.sv */
// Checker for the BMP stream decoder: predicts results per input byte and compares them.
`default_nettype none
module bmp_decode_checker
  import bsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [STEP_W-1:0] cfg_wr_data,
  bsd_in_if                      in_mon,
  bsd_out_if                     out_mon,
  output int                     pending,
  output int                     fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    err_t               err;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RGB_W-1:0]   rgb;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic               last;
  } result_t;

  // Decoder model state
  logic [STEP_W-1:0]    step_reg;
  phase_t               phase;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [15:0]          sig_w;
  logic [31:0]          width_w;
  logic [31:0]          height_w;
  logic [15:0]          depth_w;
  logic [COORD_W-1:0]   row_cnt;
  logic [ROWB_W-1:0]    in_row;
  logic [RGB_W-1:0]     pix_asm;
  logic [1:0]           in_pix;

  result_t expected_q[$];

  function void clear_stream();
    phase    = PH_HEADER;
    hdr_idx  = '0;
    sig_w    = '0;
    width_w  = '0;
    height_w = '0;
    depth_w  = '0;
    row_cnt  = '0;
    in_row   = '0;
    pix_asm  = '0;
    in_pix   = '0;
  endfunction

  function logic [31:0] abs_height();
    return height_w[31] ? (32'd0 - height_w) : height_w;
  endfunction

  function automatic result_t make_result(kind_t kind, err_t err, logic [31:0] x, y,
                                          logic [RGB_W-1:0] rgb, logic [31:0] w, h);
    result_t r;
    r.kind = kind;
    r.err  = err;
    r.x    = x[COORD_W-1:0];
    r.y    = y[COORD_W-1:0];
    r.rgb  = rgb;
    r.w    = w[DIM_W-1:0];
    r.h    = h[DIM_W-1:0];
    r.last = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    result_t     run[$];
    logic [31:0] h_abs;
    logic [31:0] bpp;
    logic [31:0] data_len;
    logic [31:0] row_len;
    logic [31:0] xpos;
    logic [31:0] ypos;
    logic [31:0] stride;
    int          idx;
    idx = int'(hdr_idx);
    case (phase)
      PH_HEADER: begin
        if (idx < 2) sig_w[8*idx +: 8] = b;
        else if (idx >= 18 && idx < 22) width_w[8*(idx-18) +: 8] = b;
        else if (idx >= 22 && idx < 26) height_w[8*(idx-22) +: 8] = b;
        else if (idx >= 28 && idx < 30) depth_w[8*(idx-28) +: 8] = b;
        h_abs = abs_height();
        if (hdr_idx == IDX_SIG_CHK && sig_w != BMP_SIGNATURE) begin
          run.push_back(make_result(KIND_ERROR, ERR_SIGNATURE, 0, 0, 0, 0, 0));
          phase = PH_ERROR;
        end else if (hdr_idx >= IDX_HDR_LAST) begin
          // size is judged before depth
          if (width_w[31] || width_w == 0 || width_w > MAX_WIDTH ||
              h_abs == 0 || h_abs > MAX_HEIGHT) begin
            run.push_back(make_result(KIND_ERROR, ERR_SIZE, 0, 0, 0, 0, 0));
            phase = PH_ERROR;
          end else if (depth_w != DEPTH_24 && depth_w != DEPTH_32) begin
            run.push_back(make_result(KIND_ERROR, ERR_DEPTH, 0, 0, 0, 0, 0));
            phase = PH_ERROR;
          end else begin
            phase   = PH_PIXELS;
            row_cnt = '0;
            in_row  = '0;
            in_pix  = '0;
            pix_asm = '0;
          end
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PH_PIXELS: begin
        h_abs    = abs_height();
        bpp      = (depth_w == DEPTH_32) ? 32'd4 : 32'd3;
        data_len = width_w * bpp;
        row_len  = (data_len + 32'd3) & ~32'd3;
        if (in_row < data_len) begin
          if (in_pix < 3) pix_asm[8*in_pix +: 8] = b;
          // all writes of a pixel go out on its red byte
          if (in_pix == 2) begin
            stride = (step_reg == 0) ? 32'd1 :
                     (step_reg > MAX_STEP) ? 32'(MAX_STEP) : 32'(step_reg);
            xpos = in_row / bpp;
            ypos = height_w[31] ? 32'(row_cnt) : h_abs - 32'd1 - row_cnt;
            if (xpos % stride == 0)
              for (int k = 0; k < stride && xpos + k < width_w; k++)
                run.push_back(make_result(KIND_PIXEL, ERR_NONE, xpos + k, ypos, pix_asm,
                                          0, 0));
          end
          in_pix = (in_pix + 32'd1 >= bpp) ? 2'd0 : in_pix + 2'd1;
        end
        in_row = in_row + 1'b1;
        if (in_row >= row_len) begin
          in_row = '0;
          in_pix = '0;
          if (row_cnt + 32'd1 >= h_abs) begin
            run.push_back(make_result(KIND_DONE, ERR_NONE, 0, 0, 0, width_w, h_abs));
            phase = PH_DONE;
          end else begin
            row_cnt = row_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (phase == PH_HEADER || phase == PH_PIXELS)
        run.push_back(make_result(KIND_ERROR, ERR_TRUNCATED, 0, 0, 0, 0, 0));
      clear_stream();
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_q.push_back(run[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: kind %0d error %0d x %0d y %0d", out_mon.result_kind,
             out_mon.error_code, out_mon.pixel_x, out_mon.pixel_y);
      fail_count++;
    end else begin
      want = expected_q.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(out_mon.result_kind));
      check_field("error_code", 32'(want.err), 32'(out_mon.error_code));
      check_field("pixel_x", 32'(want.x), 32'(out_mon.pixel_x));
      check_field("pixel_y", 32'(want.y), 32'(out_mon.pixel_y));
      check_field("pixel_rgb", 32'(want.rgb), 32'(out_mon.pixel_rgb));
      check_field("image_width", 32'(want.w), 32'(out_mon.image_width));
      check_field("image_height", 32'(want.h), 32'(out_mon.image_height));
      check_field("last_of_run", 32'(want.last), 32'(out_mon.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_reg   = STEP_W'(1);
      fail_count = 0;
      clear_stream();
      expected_q.delete();
    end else begin
      if (cfg_wr_en) step_reg = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.file_byte, in_mon.end_of_file);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Top of the BMP stream decoder testbench: clock, reset, file stimulus and verdict.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsd_pkg::*;

  localparam int HEADER_BYTES = 54;
  localparam int SIG_BYTES    = 14;
  localparam int HOLD_CYCLES  = 150;   // long receiver stall, fills the job queue
  localparam int DRAIN_CYCLES = 4;     // margin over the parser, queue register and output register path

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [STEP_W-1:0] cfg_wr_data;

  bsd_in_if  in_ch ();
  bsd_out_if out_ch ();

  int pending;
  int fail_count;

  // Idle knobs, redrawn per file so that gap-free stretches occur too.
  bit src_idle_on;
  bit snk_idle_on;
  // Set by the stimulus to make the receiver stall once for a long stretch.
  bit long_hold_due;

  // Bytes of the file under construction.
  logic [7:0] file_q[$];

  bmp_stream_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_ch),
    .out_bus     (out_ch)
  );

  // Watches both channels, predicts every result and counts mismatches.
  bmp_decode_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds the 54-byte file and info header. Bytes the decoder does not
  // look at (file size, data offset, planes, ...) are random.
  task automatic header_bytes(input logic [15:0] sig, input logic [31:0] wid, hgt,
                              input logic [15:0] dep);
    logic [7:0] b;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = 8'($urandom);
      if (i < 2) b = sig[8*i +: 8];
      else if (i >= 18 && i < 22) b = wid[8*(i-18) +: 8];
      else if (i >= 22 && i < 26) b = hgt[8*(i-22) +: 8];
      else if (i >= 28 && i < 30) b = dep[8*(i-28) +: 8];
      file_q.push_back(b);
    end
  endtask

  // Appends random pixel data for a whole image, each row padded to a multiple of 4 bytes.
  task automatic image_bytes(input logic [31:0] wid, hgt, input logic [15:0] dep);
    logic [31:0] rows;
    logic [31:0] row_len;
    rows    = hgt[31] ? (32'd0 - hgt) : hgt;
    row_len = ((wid * ((dep == DEPTH_32) ? 32'd4 : 32'd3)) + 32'd3) & ~32'd3;
    repeat (row_len * rows) file_q.push_back(8'($urandom));
  endtask

  // Cuts the file short; end_of_file then lands on the last kept byte.
  task automatic truncate_to(input int n);
    while (file_q.size() > n) void'(file_q.pop_back());
  endtask

  // Offers the file one byte per transaction, end_of_file on the last one.
  // A new file always starts after an idle gap, so valid is never
  // dropped and raised in the same step.
  task automatic send_file();
    int gap;
    gap = $urandom_range(5, 1);
    foreach (file_q[i]) begin
      repeat (gap) @(posedge clk);
      in_ch.valid       <= 1'b1;
      in_ch.file_byte   <= file_q[i];
      in_ch.end_of_file <= (i == file_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      gap = src_idle_on ? $urandom_range(5, 0) : 0;
      if (gap != 0 || i == file_q.size() - 1) in_ch.valid <= 1'b0;
    end
    file_q.delete();
  endtask

  task automatic send_header(input logic [15:0] sig, input logic [31:0] wid, hgt,
                             input logic [15:0] dep);
    header_bytes(sig, wid, hgt, dep);
    send_file();
  endtask

  // Waits until every predicted result has come out, then waits out the DRAIN_CYCLES margin
  // in case the last bytes still sit in the pipe without results.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Step register is only touched while the decoder is idle.
  task automatic write_step(input logic [STEP_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: random ready gaps per transaction, plus one long stall on request.
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = snk_idle_on ? $urandom_range(5, 0) : 0;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    logic [15:0] sig;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [15:0] dep;
    int          mode;
    int          tail;
    int          random_bytes;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.file_byte   = '0;
    in_ch.end_of_file = 1'b0;
    src_idle_on       = 1'b1;
    snk_idle_on       = 1'b1;
    long_hold_due     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---------------- directed files ----------------
    // Step 0 must behave as step 1.
    write_step('0);

    // One-byte file: truncated while still in the header.
    file_q.push_back(8'($urandom));
    send_file();

    // Bad signature, file ends on the very byte that flags it: no truncation.
    header_bytes(16'h4D43, 32'd1, 32'd1, DEPTH_24);
    truncate_to(SIG_BYTES);
    send_file();

    // Most negative height counts as too large.
    send_header(BMP_SIGNATURE, 32'd1, 32'h8000_0000, DEPTH_24);
    // Size error wins over a bad depth.
    send_header(BMP_SIGNATURE, 32'd0, 32'd1, 16'd16);

    // Full-width top-down image cut short, receiver stalls long meanwhile so
    // the job queue fills and the input side backs up.
    write_step(STEP_W'(1));
    src_idle_on   = 1'b0;
    long_hold_due = 1'b1;
    header_bytes(BMP_SIGNATURE, 32'(MAX_WIDTH), -32'(MAX_HEIGHT), DEPTH_24);
    repeat (21) file_q.push_back(8'($urandom));
    send_file();
    src_idle_on = 1'b1;

    // Step 15 clamps to the maximum; on a 10-wide row the second sampled
    // pixel is clipped at the width. End of file on the completion byte
    // gives no truncation error.
    write_step('1);
    header_bytes(BMP_SIGNATURE, 32'd10, 32'd1, DEPTH_32);
    image_bytes(32'd10, 32'd1, DEPTH_32);
    send_file();

    // ---------------- random files ----------------
    // Mostly well-formed images with random content, some broken headers,
    // some cut short, some with trailing bytes.
    random_bytes = 0;
    while (random_bytes < 60) begin
      if ($urandom_range(2, 0) == 0) write_step(STEP_W'($urandom));
      src_idle_on = ($urandom_range(3, 0) != 0);
      snk_idle_on = ($urandom_range(3, 0) != 0);
      sig = BMP_SIGNATURE;
      wid = $urandom_range(6, 1);
      hgt = $urandom_range(3, 1);
      if ($urandom_range(1, 0) != 0) hgt = 32'd0 - hgt;
      dep = ($urandom_range(1, 0) != 0) ? DEPTH_32 : DEPTH_24;
      mode = $urandom_range(19, 0);
      case (mode)
        0: sig = BMP_SIGNATURE ^ 16'($urandom_range(16'hFFFF, 1));
        1: begin
          case ($urandom_range(4, 0))
            0: wid = '0;
            1: wid = 32'h8000_0000 | 32'($urandom);
            2: wid = 32'(MAX_WIDTH + 1) + $urandom_range(4000, 0);
            3: hgt = '0;
            default: hgt = 32'd0 - (32'(MAX_HEIGHT + 1) + $urandom_range(4000, 0));
          endcase
        end
        2: begin
          dep = 16'($urandom);
          if (dep == DEPTH_24 || dep == DEPTH_32) dep = dep ^ 16'h0100;
        end
        default: ;
      endcase
      header_bytes(sig, wid, hgt, dep);
      if (mode > 2) image_bytes(wid, hgt, dep);
      tail = $urandom_range(9, 0);
      if (tail < 2) truncate_to($urandom_range(file_q.size() - 1, 1));
      else if (tail == 2) repeat ($urandom_range(4, 1)) file_q.push_back(8'($urandom));
      random_bytes += file_q.size();
      send_file();
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
